// ===== rtl/beat_grid_jump_target_assert.svh =====
// assertion macros for the beat grid jump target block
`ifndef BEAT_GRID_JUMP_TARGET_ASSERT_SVH
`define BEAT_GRID_JUMP_TARGET_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BGJT_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("bgjt check failed");
// next-cycle implication
`define BGJT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("bgjt check failed");
`else
`define BGJT_ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define BGJT_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ===== rtl/bgjt_pkg.sv =====
package bgjt_pkg;

  localparam int DEF_BEAT_SLOTS = 1024;

  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [15:0] DEFAULT_TEMPO = 16'd120;
  localparam logic [31:0] MAX_MS        = 32'hFFFF_FFFF;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_BPM = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [9:0]         entry_index;
    logic [31:0]        beat_time_ms;
    logic [31:0]        play_pos;
    logic signed [11:0] jump_beats;
  } in_item_t;

  typedef struct packed {
    logic [31:0] jump_ms;
    logic        from_grid;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_LATCH,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/bgjt_div.sv =====
module bgjt_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0]         divisor,
  output bgjt_pkg::div_status_t status,
  output logic [15:0]         quotient
);
  import bgjt_pkg::*;

  // restoring division of the minute length, one quotient bit per cycle
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, quo[15]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= MS_PER_MINUTE;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quo <= {quo[14:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

// ===== rtl/beat_grid_jump_target.sv =====
// load: written to the table when accepted, no result; the next item may follow at once
// grid query (grid_size > 0): the table is scanned for the entry nearest play_pos, one read
//   per cycle, then the shifted entry is fetched and registered; no new item is taken until done
// tempo query (grid_size = 0): beat length from the 16-step divider, times the shift, plus
//   the position; a held output stalls both query cases in ST_DONE
// reset: synchronous, clears control, grid_size = 0, tempo_bpm = 120; table undefined
module beat_grid_jump_target #(
  parameter int BEAT_SLOTS = bgjt_pkg::DEF_BEAT_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bgjt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bgjt_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bgjt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgjt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bgjt_pkg::*;

  `include "beat_grid_jump_target_assert.svh"

  // table addressing and effective grid size widths
  localparam int ADDR_W = (BEAT_SLOTS > 1) ? $clog2(BEAT_SLOTS) : 1;
  localparam int CNT_W  = $clog2(BEAT_SLOTS + 1);
  localparam int IW     = ((ADDR_W > 11) ? ADDR_W : 11) + 2;

  // configuration registers
  logic [10:0] grid_size;
  logic [15:0] tempo_bpm;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= '0;
      tempo_bpm <= DEFAULT_TEMPO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIZE: grid_size <= cfg_data[10:0];
        CFG_TEMPO_BPM: tempo_bpm <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // grid size clipped to the table depth
  logic [16:0]      grid_ext;
  logic [CNT_W-1:0] count;

  assign grid_ext = {6'b0, grid_size};
  assign count    = (grid_ext < 17'(BEAT_SLOTS)) ? CNT_W'(grid_ext) : CNT_W'(BEAT_SLOTS);

  // control
  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   is_query;
  logic   scan_last;
  logic   out_free;
  logic   rd_en;
  logic   div_start;

  logic [ADDR_W-1:0] scan_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] fetch_addr;

  div_status_t div_stat;
  logic [15:0] div_quo;
  logic [15:0] bpm_eff;

  assign in_fire   = in_valid && in_ready;
  assign is_query  = (in_data.operation == OP_QUERY);
  assign scan_last = (CNT_W'(scan_idx) == CNT_W'(count - CNT_W'(1)));
  assign out_free  = !out_valid || out_ready;
  assign bpm_eff   = (tempo_bpm == 16'd0) ? DEFAULT_TEMPO : tempo_bpm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && is_query) begin
          state_next = (count != '0) ? ST_SCAN : ST_DIV;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FETCH;
      ST_FETCH: state_next = ST_LATCH;
      ST_LATCH: state_next = ST_DONE;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = scan_idx;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && is_query && (count == '0);
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_idx;
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = fetch_addr;
      end
      default: ;
    endcase
  end

  // beat table, one write port for loads and one registered read port
  logic [31:0] beat_table [BEAT_SLOTS];
  logic [31:0] rd_data;
  logic        mem_we;

  assign mem_we = in_fire && !is_query && ({7'b0, in_data.entry_index} < 17'(BEAT_SLOTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      beat_table[ADDR_W'(in_data.entry_index)] <= in_data.beat_time_ms;
    end
    if (rd_en) begin
      rd_data <= beat_table[rd_addr];
    end
  end

  // query operands held for the whole query
  logic [31:0]        pos_q;
  logic signed [11:0] shift_q;

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      pos_q   <= in_data.play_pos;
      shift_q <= in_data.jump_beats;
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
  end

  // compare stage: read data arrives in the cycle after its address
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_idx;
  logic [ADDR_W-1:0] best;
  logic [31:0]       best_diff;
  logic [31:0]       diff;

  assign diff = (pos_q > rd_data) ? (pos_q - rd_data) : (rd_data - pos_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      pend_idx <= scan_idx;
    end
    if (in_fire) begin
      best      <= '0;
      best_diff <= MAX_MS;
    end else if (pend_valid && (diff < best_diff)) begin
      // strict less-than keeps the first minimum on ties
      best      <= pend_idx;
      best_diff <= diff;
    end
  end

  // shifted index, clamped into the grid
  logic signed [IW-1:0] idx_s;
  logic signed [IW-1:0] cnt_s;

  assign idx_s = IW'($signed({1'b0, best})) + IW'(shift_q);
  assign cnt_s = $signed(IW'(count));

  always_comb begin
    priority if (idx_s < 0) begin
      fetch_addr = '0;
    end else if (idx_s >= cnt_s) begin
      fetch_addr = ADDR_W'(cnt_s - IW'(1));
    end else begin
      fetch_addr = ADDR_W'(idx_s);
    end
  end

  // tempo path: beat length from the divider, times the shift, plus the position
  bgjt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (bpm_eff),
    .status   (div_stat),
    .quotient (div_quo)
  );

  logic signed [28:0] prod;
  logic signed [33:0] sum_t;

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= $signed({1'b0, div_quo}) * shift_q;
    end
  end

  assign sum_t = $signed({2'b0, pos_q}) + 34'(prod);

  // result register, held until the output slot frees up
  logic [31:0] res_ms;
  logic        res_grid;

  always_ff @(posedge clk) begin
    if (state == ST_LATCH) begin
      res_ms   <= rd_data;
      res_grid <= 1'b1;
    end else if (state == ST_SUM) begin
      res_grid <= 1'b0;
      // floor at zero, saturate at the top of the 32-bit range
      priority if (sum_t[33] || (sum_t == '0)) begin
        res_ms <= '0;
      end else if (sum_t[32]) begin
        res_ms <= MAX_MS;
      end else begin
        res_ms <= sum_t[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_data.jump_ms   <= res_ms;
      out_data.from_grid <= res_grid;
    end
  end

  // checks
  `BGJT_ASSERT_IMPL(a_busy_blocks_input, clk, rst, state != ST_IDLE, !in_ready)
  `BGJT_ASSERT_IMPL(a_div_done_in_div, clk, rst, div_stat.done, state == ST_DIV)
  `BGJT_ASSERT_IMPL(a_scan_in_grid, clk, rst, state == ST_SCAN, CNT_W'(scan_idx) < count)
  `BGJT_ASSERT_NEXT(a_query_starts_work, clk, rst, in_fire && is_query, state != ST_IDLE)

endmodule
